>>> hdl/ldc_pkg.sv
package ldc_pkg;

  localparam int unsigned MaxChannels = 32;

  localparam int unsigned ChanW   = 5;
  localparam int unsigned SampleW = 24;
  localparam int unsigned VelW    = 48;
  localparam int unsigned PosW    = 64;
  localparam int unsigned CoefW   = 32;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CoefW-1:0] GainReset   = 32'd1288490189;
  localparam logic [CoefW-1:0] DecayReset  = 32'd4294924346;
  localparam logic [CoefW-1:0] StiffReset  = 32'd1675037;
  localparam logic [CoefW-1:0] LeakReset   = 32'd4294924346;
  localparam logic [CoefW-1:0] BypassReset = 32'd0;

  typedef enum logic [CfgIdxW-1:0] {
    REG_INPUT_GAIN     = 3'd0,
    REG_VELOCITY_DECAY = 3'd1,
    REG_STIFFNESS      = 3'd2,
    REG_POSITION_LEAK  = 3'd3,
    REG_BYPASS_MASK    = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [CoefW-1:0] input_gain;
    logic [CoefW-1:0] velocity_decay;
    logic [CoefW-1:0] stiffness;
    logic [CoefW-1:0] position_leak;
    logic [CoefW-1:0] bypass_mask;
  } coef_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } store_cmd_t;

endpackage

>>> hdl/ldc_mulq.sv
module ldc_mulq (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [ldc_pkg::PosW-1:0]    a_i,
  input  logic        [ldc_pkg::CoefW-1:0]   c_i,
  output logic                               done_o,
  output logic signed [ldc_pkg::PosW-1:0]    res_o
);
  import ldc_pkg::*;

  typedef enum logic [4:0] {
    M_IDLE = 5'b00001,
    M_LO   = 5'b00010,
    M_HI   = 5'b00100,
    M_SUM  = 5'b01000,
    M_DONE = 5'b10000
  } mul_state_e;

  mul_state_e state_q, state_d;

  logic             neg_q;
  logic [PosW-1:0]  m_q;
  logic [CoefW-1:0] c_q;
  logic [PosW-1:0]  p_q;
  logic [CoefW-1:0] lo_q;
  logic [PosW-1:0]  r_q;

  logic [CoefW-1:0] mul_a;
  logic [PosW-1:0]  prod;
  logic [PosW-1:0]  rnd_sum;

  // One 32x32 multiplier serves the low and the high half of the magnitude.
  assign mul_a   = (state_q == M_LO) ? m_q[CoefW-1:0] : m_q[PosW-1:CoefW];
  assign prod    = PosW'(mul_a) * PosW'(c_q);
  assign rnd_sum = p_q + (PosW'(1) << (CoefW - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      M_IDLE:  if (start_i) state_d = M_LO;
      M_LO:    state_d = M_HI;
      M_HI:    state_d = M_SUM;
      M_SUM:   state_d = M_DONE;
      M_DONE:  state_d = M_IDLE;
      default: state_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && state_q == M_IDLE) begin
      neg_q <= a_i[PosW-1];
      m_q   <= a_i[PosW-1] ? PosW'(-a_i) : PosW'(a_i);
      c_q   <= c_i;
    end
    if (state_q == M_LO) begin
      p_q <= prod;
    end
    if (state_q == M_HI) begin
      p_q  <= prod;
      lo_q <= rnd_sum[PosW-1:CoefW];
    end
    if (state_q == M_SUM) begin
      r_q <= p_q + PosW'(lo_q);
    end
  end

  // The rounded magnitude never exceeds the operand's, so negation cannot overflow
  // except for the most negative value, which wraps to itself.
  assign res_o  = signed'(neg_q ? (~r_q + 1'b1) : r_q);
  assign done_o = (state_q == M_DONE);

endmodule

>>> hdl/ldc_store.sv
module ldc_store #(
  parameter int unsigned CHANNELS = ldc_pkg::MaxChannels
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  ldc_pkg::store_cmd_t                               cmd_i,
  input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] addr_i,
  input  logic signed [ldc_pkg::VelW-1:0]                   vel_wr_i,
  input  logic signed [ldc_pkg::PosW-1:0]                   pos_wr_i,
  output logic signed [ldc_pkg::VelW-1:0]                   vel_rd_o,
  output logic signed [ldc_pkg::PosW-1:0]                   pos_rd_o
);
  import ldc_pkg::*;

  logic [VelW-1:0] vel_mem [CHANNELS];
  logic [PosW-1:0] pos_mem [CHANNELS];

  logic [CHANNELS-1:0] valid_q;
  logic                rd_valid_q;
  logic [VelW-1:0]     vel_rd_q;
  logic [PosW-1:0]     pos_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      vel_mem[addr_i] <= vel_wr_i;
      pos_mem[addr_i] <= pos_wr_i;
    end
    if (cmd_i.rd_en) begin
      vel_rd_q <= vel_mem[addr_i];
      pos_rd_q <= pos_mem[addr_i];
    end
  end

  // An entry that was never written since reset reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (cmd_i.wr_en) begin
        valid_q[addr_i] <= 1'b1;
      end
      if (cmd_i.rd_en) begin
        rd_valid_q <= valid_q[addr_i];
      end
    end
  end

  assign vel_rd_o = rd_valid_q ? signed'(vel_rd_q) : '0;
  assign pos_rd_o = rd_valid_q ? signed'(pos_rd_q) : '0;

endmodule

>>> hdl/ldc_ctrl.sv
module ldc_ctrl #(
  parameter int unsigned CHANNELS = ldc_pkg::MaxChannels
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  ldc_pkg::coef_t                       coef_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [ldc_pkg::ChanW-1:0]            channel_i,
  input  logic signed [ldc_pkg::SampleW-1:0]   sample_in_i,
  input  logic                                 clear_state_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [ldc_pkg::ChanW-1:0]            channel_out_o,
  output logic signed [ldc_pkg::SampleW-1:0]   sample_out_o,
  output logic                                 clipped_o
);
  import ldc_pkg::*;

  localparam int unsigned AddrW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_READ   = 13'b0000000000010,
    S_GAIN   = 13'b0000000000100,
    S_WGAIN  = 13'b0000000001000,
    S_DEC    = 13'b0000000010000,
    S_WDEC   = 13'b0000000100000,
    S_POS    = 13'b0000001000000,
    S_STF    = 13'b0000010000000,
    S_WSTF   = 13'b0000100000000,
    S_LEAK   = 13'b0001000000000,
    S_WLEAK  = 13'b0010000000000,
    S_WB     = 13'b0100000000000,
    S_RESULT = 13'b1000000000000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q;

  logic [ChanW-1:0]          ch_q;
  logic signed [SampleW-1:0] x_q;
  logic                      clr_q;
  logic signed [SampleW-1:0] v_q;
  logic signed [VelW-1:0]    vel_q;
  logic signed [PosW-1:0]    pos_q;
  logic signed [SampleW-1:0] y_q;
  logic                      clip_q;

  logic [ChanW-1:0]          chan_out_q;
  logic signed [SampleW-1:0] sample_out_q;
  logic                      clipped_out_q;

  logic in_acc;
  logic byp;
  logic out_load;

  store_cmd_t             store_cmd;
  logic signed [VelW-1:0] vel_rd;
  logic signed [PosW-1:0] pos_rd;

  logic                   mul_start;
  logic signed [PosW-1:0] mul_a;
  logic [CoefW-1:0]       mul_c;
  logic                   mul_done;
  logic signed [PosW-1:0] mul_res;

  logic signed [VelW:0] vel_sum;
  logic                 vel_ovf;
  logic [VelW-1:0]      vel_sat;
  logic signed [PosW:0] pos_sum;
  logic                 pos_ovf;
  logic [PosW-1:0]      pos_sat;
  logic signed [PosW:0] y_sum;
  logic                 y_fits;
  logic [SampleW-1:0]   y_sat;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  // Channels past the configured count pass through like bypassed ones.
  assign byp = ({1'b0, channel_i} >= (ChanW + 1)'(CHANNELS)) || coef_i.bypass_mask[channel_i];

  // The result register frees the sequencer as soon as the previous result is transferred.
  assign out_load = (state_q == S_RESULT) && (!out_valid_q || !out_stall_i);

  assign store_cmd.rd_en = (state_q == S_READ);
  assign store_cmd.wr_en = (state_q == S_WB);

  ldc_store #(
    .CHANNELS (CHANNELS)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (store_cmd),
    .addr_i   (ch_q[AddrW-1:0]),
    .vel_wr_i (vel_q),
    .pos_wr_i (pos_q),
    .vel_rd_o (vel_rd),
    .pos_rd_o (pos_rd)
  );

  always_comb begin
    mul_start = state_q inside {S_GAIN, S_DEC, S_STF, S_LEAK};
    case (state_q)
      S_GAIN: begin
        mul_a = PosW'(x_q);
        mul_c = coef_i.input_gain;
      end
      S_DEC: begin
        mul_a = PosW'(vel_q);
        mul_c = coef_i.velocity_decay;
      end
      S_STF: begin
        mul_a = pos_q;
        mul_c = coef_i.stiffness;
      end
      default: begin
        mul_a = pos_q;
        mul_c = coef_i.position_leak;
      end
    endcase
  end

  ldc_mulq u_mulq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .c_i     (mul_c),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  // Saturating sums: the saturated value is the sign bit followed by its complement.
  assign vel_sum = (VelW + 1)'(signed'(mul_res[VelW-1:0])) + (VelW + 1)'(v_q);
  assign vel_ovf = vel_sum[VelW] != vel_sum[VelW-1];
  assign vel_sat = {vel_sum[VelW], {(VelW - 1){~vel_sum[VelW]}}};

  assign pos_sum = (PosW + 1)'(pos_q) + (PosW + 1)'(vel_q);
  assign pos_ovf = pos_sum[PosW] != pos_sum[PosW-1];
  assign pos_sat = {pos_sum[PosW], {(PosW - 1){~pos_sum[PosW]}}};

  // Clamping the wide sum straight to the sample range gives the same value and flag
  // as saturating it to 64 bits first.
  assign y_sum  = (PosW + 1)'(mul_res) + (PosW + 1)'(v_q);
  assign y_fits = (&y_sum[PosW:SampleW-1]) || !(|y_sum[PosW:SampleW-1]);
  assign y_sat  = {y_sum[PosW], {(SampleW - 1){~y_sum[PosW]}}};

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_acc) state_d = byp ? S_RESULT : S_READ;
      S_READ:   state_d = S_GAIN;
      S_GAIN:   state_d = S_WGAIN;
      S_WGAIN:  if (mul_done) state_d = S_DEC;
      S_DEC:    state_d = S_WDEC;
      S_WDEC:   if (mul_done) state_d = S_POS;
      S_POS:    state_d = S_STF;
      S_STF:    state_d = S_WSTF;
      S_WSTF:   if (mul_done) state_d = S_LEAK;
      S_LEAK:   state_d = S_WLEAK;
      S_WLEAK:  if (mul_done) state_d = S_WB;
      S_WB:     state_d = S_RESULT;
      S_RESULT: if (out_load) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ch_q   <= channel_i;
      x_q    <= sample_in_i;
      clr_q  <= clear_state_i;
      y_q    <= sample_in_i;
      clip_q <= 1'b0;
    end
    if (state_q == S_GAIN) begin
      vel_q <= clr_q ? '0 : vel_rd;
      pos_q <= clr_q ? '0 : pos_rd;
    end
    if (state_q == S_WGAIN && mul_done) begin
      v_q <= mul_res[SampleW-1:0];
    end
    if (state_q == S_WDEC && mul_done) begin
      vel_q <= vel_ovf ? vel_sat : vel_sum[VelW-1:0];
      if (vel_ovf) begin
        clip_q <= 1'b1;
      end
    end
    if (state_q == S_POS) begin
      pos_q <= pos_ovf ? pos_sat : pos_sum[PosW-1:0];
      if (pos_ovf) begin
        clip_q <= 1'b1;
      end
    end
    if (state_q == S_WSTF && mul_done) begin
      y_q <= y_fits ? y_sum[SampleW-1:0] : y_sat;
      if (!y_fits) begin
        clip_q <= 1'b1;
      end
    end
    if (state_q == S_WLEAK && mul_done) begin
      pos_q <= mul_res;
    end
    if (out_load) begin
      chan_out_q    <= ch_q;
      sample_out_q  <= y_q;
      clipped_out_q <= clip_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign channel_out_o = chan_out_q;
  assign sample_out_o  = sample_out_q;
  assign clipped_o     = clipped_out_q;

endmodule

>>> hdl/loudspeaker_driver_compensator_top.sv
// Loudspeaker membrane compensator for interleaved 24-bit audio. Each channel keeps a
// velocity and a position in on-chip memory (both read as zero after reset) and one sample
// at a time is processed: the sequencer reads the channel's state, runs the four
// coefficient products through a single shared 32x32 multiplier (two partial products and
// a rounding add per product), and writes the state back before the next sample is
// taken, so no forwarding between samples is needed. A bypassed channel, or a channel
// index at or above CHANNELS, skips the state memory and the multiplier. The input is
// taken again while the last result still waits in the output register. Coefficient
// registers may be written at any time the block is idle.
module loudspeaker_driver_compensator_top #(
  parameter int unsigned CHANNELS = ldc_pkg::MaxChannels
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [ldc_pkg::ChanW-1:0]            channel_i,
  input  logic signed [ldc_pkg::SampleW-1:0]   sample_in_i,
  input  logic                                 clear_state_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [ldc_pkg::ChanW-1:0]            channel_out_o,
  output logic signed [ldc_pkg::SampleW-1:0]   sample_out_o,
  output logic                                 clipped_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [ldc_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [ldc_pkg::CoefW-1:0]            cfg_data_i
);
  import ldc_pkg::*;

  coef_t coef_q;
  logic  cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  // A transfer to an index beyond the register list is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.input_gain     <= GainReset;
      coef_q.velocity_decay <= DecayReset;
      coef_q.stiffness      <= StiffReset;
      coef_q.position_leak  <= LeakReset;
      coef_q.bypass_mask    <= BypassReset;
    end else if (cfg_wr) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_INPUT_GAIN:     coef_q.input_gain     <= cfg_data_i;
        REG_VELOCITY_DECAY: coef_q.velocity_decay <= cfg_data_i;
        REG_STIFFNESS:      coef_q.stiffness      <= cfg_data_i;
        REG_POSITION_LEAK:  coef_q.position_leak  <= cfg_data_i;
        REG_BYPASS_MASK:    coef_q.bypass_mask    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ldc_ctrl #(
    .CHANNELS (CHANNELS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .coef_i        (coef_q),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .channel_i     (channel_i),
    .sample_in_i   (sample_in_i),
    .clear_state_i (clear_state_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .channel_out_o (channel_out_o),
    .sample_out_o  (sample_out_o),
    .clipped_o     (clipped_o)
  );

endmodule

>>> test/ldc_result_checker.sv
module ldc_result_checker #(
  parameter int unsigned CHANNELS = ldc_pkg::MaxChannels
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_stall_i,
  input  logic [ldc_pkg::ChanW-1:0]          channel_i,
  input  logic signed [ldc_pkg::SampleW-1:0] sample_in_i,
  input  logic                               clear_state_i,
  input  logic                               out_valid_i,
  input  logic                               out_stall_i,
  input  logic [ldc_pkg::ChanW-1:0]          channel_out_i,
  input  logic signed [ldc_pkg::SampleW-1:0] sample_out_i,
  input  logic                               clipped_i,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_i,
  input  logic [ldc_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [ldc_pkg::CoefW-1:0]          cfg_data_i,
  output int unsigned                        fail_count_o,
  output int unsigned                        pending_o
);
  import ldc_pkg::*;

  localparam logic signed [63:0] VelMax = 64'sd140737488355327;
  localparam logic signed [63:0] VelMin = -VelMax - 64'sd1;
  localparam logic signed [63:0] OutMax = 64'sd8388607;
  localparam logic signed [63:0] OutMin = -64'sd8388608;

  typedef struct packed {
    logic [ChanW-1:0]          chan;
    logic signed [SampleW-1:0] smp;
    logic                      clip;
  } comp_result_t;

  coef_t                    coefs;
  logic signed [VelW-1:0]   velocity_mem [CHANNELS];
  logic signed [PosW-1:0]   position_mem [CHANNELS];
  comp_result_t             due_results [$];
  int unsigned              mismatch_count;

  // Coefficient product, magnitude rounded to nearest with ties away from zero.
  function automatic logic signed [63:0] scale_q32(input logic signed [63:0] a,
                                                   input logic [CoefW-1:0] c);
    logic [63:0]  mag;
    logic [127:0] prod;
    mag = a[63] ? -a : a;
    prod = {64'd0, mag} * {96'd0, c} + 128'h8000_0000;
    return a[63] ? -prod[95:32] : prod[95:32];
  endfunction

  function automatic logic signed [63:0] sat_sum64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b,
                                                   inout bit clip);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) begin
      clip = 1'b1;
      return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

  function automatic comp_result_t compensate(input logic [ChanW-1:0] chan,
                                              input logic signed [SampleW-1:0] smp,
                                              input logic clr);
    comp_result_t       res;
    logic signed [63:0] v;
    logic signed [63:0] vel;
    logic signed [63:0] pos;
    logic signed [63:0] y;
    bit                 clip;
    clip = 1'b0;
    res.chan = chan;
    res.smp = smp;
    res.clip = 1'b0;
    if (chan < CHANNELS && !coefs.bypass_mask[chan]) begin
      if (clr) begin
        velocity_mem[chan] = '0;
        position_mem[chan] = '0;
      end
      v = scale_q32(64'(smp), coefs.input_gain);
      vel = scale_q32(64'(velocity_mem[chan]), coefs.velocity_decay) + v;
      if (vel > VelMax) begin
        vel = VelMax;
        clip = 1'b1;
      end else if (vel < VelMin) begin
        vel = VelMin;
        clip = 1'b1;
      end
      pos = sat_sum64(position_mem[chan], vel, clip);
      y = sat_sum64(v, scale_q32(pos, coefs.stiffness), clip);
      if (y > OutMax) begin
        y = OutMax;
        clip = 1'b1;
      end else if (y < OutMin) begin
        y = OutMin;
        clip = 1'b1;
      end
      velocity_mem[chan] = vel[VelW-1:0];
      position_mem[chan] = scale_q32(pos, coefs.position_leak);
      res.smp = y[SampleW-1:0];
      res.clip = clip;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    comp_result_t seen;
    comp_result_t want;
    if (!rst_ni) begin
      coefs.input_gain     = GainReset;
      coefs.velocity_decay = DecayReset;
      coefs.stiffness      = StiffReset;
      coefs.position_leak  = LeakReset;
      coefs.bypass_mask    = BypassReset;
      for (int c = 0; c < CHANNELS; c++) begin
        velocity_mem[c] = '0;
        position_mem[c] = '0;
      end
      due_results.delete();
      mismatch_count = 0;
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_INPUT_GAIN:     coefs.input_gain = cfg_data_i;
          REG_VELOCITY_DECAY: coefs.velocity_decay = cfg_data_i;
          REG_STIFFNESS:      coefs.stiffness = cfg_data_i;
          REG_POSITION_LEAK:  coefs.position_leak = cfg_data_i;
          REG_BYPASS_MASK:    coefs.bypass_mask = cfg_data_i;
          default: ;
        endcase
      end
      // The result leaving now always belongs to an earlier transfer, so compare first.
      if (out_valid_i && !out_stall_i) begin
        seen.chan = channel_out_i;
        seen.smp = sample_out_i;
        seen.clip = clipped_i;
        if (due_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none, got channel %0d sample %0d clip %0b",
                   $time, seen.chan, seen.smp, seen.clip);
        end else begin
          want = due_results.pop_front();
          if (seen.chan !== want.chan) begin
            mismatch_count++;
            $display("%0t: channel_out expected %0d, got %0d", $time, want.chan, seen.chan);
          end
          if (seen.smp !== want.smp) begin
            mismatch_count++;
            $display("%0t: sample_out expected %0d, got %0d", $time, want.smp, seen.smp);
          end
          if (seen.clip !== want.clip) begin
            mismatch_count++;
            $display("%0t: clipped expected %0b, got %0b", $time, want.clip, seen.clip);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        due_results.push_back(compensate(channel_i, sample_in_i, clear_state_i));
      end
      pending_o <= due_results.size();
      fail_count_o <= mismatch_count;
    end
  end

endmodule

>>> test/loudspeaker_driver_compensator_top_tb.sv
module loudspeaker_driver_compensator_top_tb;
  import ldc_pkg::*;

  localparam int unsigned Phases        = 9;
  localparam int unsigned ItemsPerPhase = 100;
  localparam int unsigned LongHold      = 300;
  localparam int unsigned QuietLimit    = 5000;
  localparam int unsigned TailCycles    = 40;

  localparam logic signed [SampleW-1:0] SampleMax = 24'sh7FFFFF;
  localparam logic signed [SampleW-1:0] SampleMin = 24'sh800000;
  localparam logic [CoefW-1:0]          CoefMax   = '1;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic [ChanW-1:0]          channel_i = '0;
  logic signed [SampleW-1:0] sample_in_i = '0;
  logic                      clear_state_i = 1'b0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic [ChanW-1:0]          channel_out_o;
  logic signed [SampleW-1:0] sample_out_o;
  logic                      clipped_o;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic [CfgIdxW-1:0]        cfg_index_i = '0;
  logic [CoefW-1:0]          cfg_data_i = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles = 0;
  bit          hold_request = 1'b0;

  always #1 clk_i = ~clk_i;

  loudspeaker_driver_compensator_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .channel_i     (channel_i),
    .sample_in_i   (sample_in_i),
    .clear_state_i (clear_state_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .channel_out_o (channel_out_o),
    .sample_out_o  (sample_out_o),
    .clipped_o     (clipped_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  ldc_result_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .channel_i     (channel_i),
    .sample_in_i   (sample_in_i),
    .clear_state_i (clear_state_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .channel_out_i (channel_out_o),
    .sample_out_i  (sample_out_o),
    .clipped_i     (clipped_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Receiver: random stalls, or one long hold-off when asked for.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic [ChanW-1:0] chan, input logic signed [SampleW-1:0] smp,
                           input logic clr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    channel_i <= chan;
    sample_in_i <= smp;
    clear_state_i <= clr;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Leaves valid high so that back-to-back writes need no second assignment in one step.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CoefW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic program_coefs(input logic [CoefW-1:0] gain, input logic [CoefW-1:0] decay,
                               input logic [CoefW-1:0] stiff, input logic [CoefW-1:0] leak,
                               input logic [CoefW-1:0] mask);
    write_reg(REG_INPUT_GAIN, gain);
    write_reg(REG_VELOCITY_DECAY, decay);
    write_reg(REG_STIFFNESS, stiff);
    write_reg(REG_POSITION_LEAK, leak);
    write_reg(REG_BYPASS_MASK, mask);
    cfg_valid_i <= 1'b0;
  endtask

  // Stops offering and waits until every transfer in flight has produced its result.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
  endtask

  initial begin
    logic [ChanW-1:0]          pool [4];
    logic [ChanW-1:0]          chan;
    logic signed [SampleW-1:0] smp;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, starting from the reset coefficients.
    send_item(0, SampleMax, 1'b1);
    send_item(0, SampleMax, 1'b0);
    send_item(0, SampleMin, 1'b0);
    send_item(31, SampleMin, 1'b1);
    send_item(31, '0, 1'b0);
    send_item(31, -24'sd1, 1'b0);
    send_item(17, 24'sd1, 1'b0);
    drain();
    // Bypassed channels pass the sample through and ignore a clear.
    program_coefs(GainReset, DecayReset, StiffReset, LeakReset, 32'h8000_0008);
    send_item(3, SampleMax, 1'b1);
    send_item(31, SampleMin, 1'b1);
    send_item(0, 24'sd12345, 1'b0);
    drain();
    // Writes to indexes past the register list must leave the coefficients alone.
    for (int idx = int'(REG_BYPASS_MASK) + 1; idx < (1 << CfgIdxW); idx++) begin
      write_reg(CfgIdxW'(idx), $urandom);
    end
    program_coefs(CoefMax, CoefMax, CoefMax, CoefMax, '0);
    send_item(7, SampleMax, 1'b1);
    repeat (5) send_item(7, SampleMax, 1'b0);
    send_item(7, SampleMin, 1'b1);
    send_item(31, '0, 1'b0);
    send_item(3, '0, 1'b0);
    drain();
    program_coefs('0, '0, '0, '0, '0);
    send_item(0, SampleMax, 1'b0);
    send_item(31, SampleMin, 1'b1);
    drain();

    for (int phase = 0; phase < Phases; phase++) begin
      if (phase < 3) begin
        send_idle_pct = 35;
        recv_stall_pct = 72;
      end else if (phase < 6) begin
        send_idle_pct = 72;
        recv_stall_pct = 35;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      case (phase)
        0: program_coefs(CoefMax, CoefMax, '0, CoefMax, '0);
        1: program_coefs($urandom, '0, CoefMax, '0, $urandom);
        2: program_coefs('0, '0, '0, '0, '0);
        3: program_coefs(GainReset, DecayReset, StiffReset, LeakReset, BypassReset);
        4: program_coefs(CoefMax, CoefMax, CoefMax, CoefMax, CoefMax);
        default: program_coefs($urandom, $urandom, $urandom >> $urandom_range(24), $urandom,
                               $urandom & $urandom & $urandom);
      endcase
      for (int k = 0; k < 4; k++) pool[k] = ChanW'($urandom_range(31));
      // Hold the output back while the sender keeps offering, so the input stalls.
      if (phase == 6) hold_request = 1'b1;
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (phase == 7 && n == ItemsPerPhase / 2) drain();
        chan = ($urandom_range(99) < 80) ? pool[2'($urandom_range(3))]
                                         : ChanW'($urandom_range(31));
        case ($urandom_range(9))
          0: smp = SampleMax;
          1: smp = SampleMin;
          2, 3: smp = 24'($urandom_range(511)) - 24'd256;
          default: smp = SampleW'($urandom);
        endcase
        send_item(chan, smp, $urandom_range(99) < 3);
      end
      drain();
    end

    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/ldc_pkg.sv
hdl/ldc_mulq.sv
hdl/ldc_store.sv
hdl/ldc_ctrl.sv
hdl/loudspeaker_driver_compensator_top.sv
test/ldc_result_checker.sv
test/loudspeaker_driver_compensator_top_tb.sv
